// File: rtl/core/dvg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dvg_pkg
// shared types and codes of the display-list vector generator
// ---------------------------------------------------------------------------
package dvg_pkg;

   // host item kinds
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_START = 2'd1,
      KIND_EXEC  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // halt reasons reported with a result
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

   // execution unit states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOST,
      ST_WORD1,
      ST_WORD2
   } state_type;

   // configuration register indexes
   localparam logic [1:0] CSR_X_SCALE = 2'd0;
   localparam logic [1:0] CSR_Y_SCALE = 2'd1;
   localparam logic [1:0] CSR_X_MIN   = 2'd2;
   localparam logic [1:0] CSR_Y_MAX   = 2'd3;

   // configuration reset values
   localparam logic [30:0] X_SCALE_RESET = 31'd65536;
   localparam logic [30:0] Y_SCALE_RESET = 31'd65536;
   localparam logic [11:0] X_MIN_RESET   = 12'd0;
   localparam logic [11:0] Y_MAX_RESET   = 12'd1023;

   // opcodes, word bits 15..12
   localparam logic [3:0] OP_LONG_FIRST = 4'd0;
   localparam logic [3:0] OP_LONG_LAST  = 4'd9;
   localparam logic [3:0] OP_ABS        = 4'd10;
   localparam logic [3:0] OP_HALT       = 4'd11;
   localparam logic [3:0] OP_CALL       = 4'd12;
   localparam logic [3:0] OP_RET        = 4'd13;
   localparam logic [3:0] OP_JUMP       = 4'd14;
   localparam logic [3:0] OP_SHORT      = 4'd15;

   // largest scale sum with its own shift, and the shift beyond it
   localparam logic [3:0] SCALE_TOP     = 4'd9;
   localparam logic [3:0] SHIFT_FLOOR   = 4'd10;
   localparam logic [3:0] SHORT_TERM    = 4'd2;

   // status that travels with a result item
   typedef struct packed {
      logic       draw;
      logic [3:0] intensity;
      logic       running;
      logic       busy;
      err_type    error;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/dvg_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dvg_req_if
// host item channel: memory writes, run control and instruction steps
// ---------------------------------------------------------------------------
interface dvg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] word_addr;
   logic [15:0] word_data;

   modport source (output valid, kind, word_addr, word_data, input ready);
   modport sink   (input valid, kind, word_addr, word_data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dvg_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dvg_rsp_if
// result item channel: beam position, intensity and run status
// ---------------------------------------------------------------------------
interface dvg_rsp_if;
   logic        valid;
   logic        ready;
   logic        draw_valid;
   logic [15:0] x_screen;
   logic [15:0] y_screen;
   logic [3:0]  intensity;
   logic        running;
   logic        busy_res;
   logic [1:0]  error_code;

   modport source (output valid, draw_valid, x_screen, y_screen, intensity, running,
                   busy_res, error_code, input ready);
   modport sink   (input valid, draw_valid, x_screen, y_screen, intensity, running,
                   busy_res, error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dvg_screen.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dvg_screen
// beam to screen coordinate: registered scale multiply, then saturation
// ---------------------------------------------------------------------------
module dvg_screen (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [31:0] beam,
   input  wire logic [30:0] scale,
   output logic      [15:0] screen
);

   localparam logic [15:0] SAT_MAX = 16'h7fff;
   localparam logic [15:0] SAT_MIN = 16'h8000;

   logic signed [26:0] coarse;
   logic signed [23:0] factor;
   logic signed [50:0] product_ff;
   logic        [37:0] scaled;
   logic               fits;

   assign coarse = $signed(beam[31:5]);
   assign factor = $signed({1'b0, scale[30:8]});

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= coarse * factor;
      end
   end

   // floor shift by 13, then clamp to 16 signed bits
   assign scaled = product_ff[50:13];
   assign fits   = (scaled[37:15] == {23{scaled[37]}});

   always_comb begin
      if (fits) begin
         screen = scaled[15:0];
      end else if (scaled[37]) begin
         screen = SAT_MIN;
      end else begin
         screen = SAT_MAX;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/digital_vector_generator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// digital_vector_generator
// display-list processor running 16-bit instruction words from its own memory
// ---------------------------------------------------------------------------
// usage
//  - req_if carries host items: write a memory word, start a run, step one
//    instruction, clear busy. every item gives exactly one rsp_if item, in order
//  - csr_we/csr_index/csr_data set scale and origin registers; write only idle
//  - the vector memory is one single-port synchronous ram; an instruction step
//    reads its first word when the item is taken and its second word (long
//    vectors, absolute loads) in the following cycle
//  - throughput: one item per cycle for host items and one-word instructions,
//    while the staging register takes results; a two-word instruction holds
//    req_if until its second word is read (two reads on one port). a result
//    goes from decode through the staging, scale multiply and output registers
//  - when rsp_if stalls the output register holds its item, the multiply and
//    staging registers fill up behind it and then req_if.ready drops
//  - reset clears the run state, the pipeline and the configuration; memory
//    and return stack contents are kept and are undefined until written
// ---------------------------------------------------------------------------
module digital_vector_generator #(
   parameter int MEM_WORDS   = 4096,
   parameter int STACK_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dvg_req_if.sink          req_if,
   dvg_rsp_if.source        rsp_if,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_data
);

   import dvg_pkg::*;

   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_TOP = SP_W'(STACK_DEPTH - 1);

   // word address modulo the memory size (MEM_WORDS of at least 128), five compare-subtract steps
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [11:0] addr);
      logic [17:0] rem;
      rem = {6'd0, addr};
      for (int k = 4; k >= 0; k--) begin
         if (rem >= (18'(MEM_WORDS) << k)) begin
            rem = rem - (18'(MEM_WORDS) << k);
         end
      end
      return rem[ADDR_W-1:0];
   endfunction

   // sign-magnitude delta times 1024, floored right shift, to 32 bits
   function automatic logic [31:0] delta_step(input logic [9:0] mag, input logic neg,
                                              input logic [3:0] shift);
      logic signed [10:0] val;
      logic signed [20:0] wide;
      val  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      wide = $signed({val, 10'd0});
      wide = wide >>> shift;
      return {{11{wide[20]}}, wide};
   endfunction

   // configuration
   logic [30:0] x_scale_ff, y_scale_ff;
   logic [11:0] x_min_ff, y_max_ff;

   // vector memory and its read register
   logic [15:0]       vmem [MEM_WORDS];
   logic [15:0]       rd_data_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;

   // architectural state
   logic [11:0]   pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [3:0]    scale_ff, scale_in;
   logic [31:0]   beam_x_ff, beam_x_in, beam_y_ff, beam_y_in;
   logic          run_ff, run_in, busy_ff, busy_in;
   logic [11:0]   stack_ff [STACK_DEPTH];

   // execution unit
   state_type   state_ff, state_in;
   kind_type    kind_ff;
   logic [15:0] w1_ff;
   logic [15:0] word1, word2;
   logic [3:0]  op;
   logic [11:0] pc_plus1, pc_plus2;
   logic [SP_W-1:0] ret_idx;
   logic        done_req, done, go_word2, push, free, accept;
   res_type     res;
   kind_type    req_kind;

   // shared vector move
   logic [3:0]  mv_term, mv_sum, mv_shift;
   logic [9:0]  mv_dx_mag, mv_dy_mag;
   logic        mv_dx_neg, mv_dy_neg;
   logic [31:0] moved_x, moved_y;

   // absolute load
   logic [12:0] diff_x, diff_y;
   logic [31:0] abs_x, abs_y;

   // result pipeline: staging, multiply, output
   logic        m_valid_ff, p_valid_ff, o_valid_ff;
   logic        m_load, p_load, o_load;
   res_type     m_res_ff, p_res_ff, o_res_ff;
   logic [31:0] m_bx_ff, m_by_ff;
   logic [15:0] x_sat, y_sat;
   logic [15:0] o_x_ff, o_y_ff;

   // ------------------------------------------------------------ config port
   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= X_SCALE_RESET;
         y_scale_ff <= Y_SCALE_RESET;
         x_min_ff   <= X_MIN_RESET;
         y_max_ff   <= Y_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_SCALE: x_scale_ff <= csr_data;
            CSR_Y_SCALE: y_scale_ff <= csr_data;
            CSR_X_MIN:   x_min_ff   <= csr_data[11:0];
            CSR_Y_MAX:   y_max_ff   <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ decode
   assign req_kind = kind_type'(req_if.kind);
   assign word1    = (state_ff == ST_WORD2) ? w1_ff : rd_data_ff;
   assign word2    = rd_data_ff;
   assign op       = word1[15:12];
   assign pc_plus1 = pc_ff + 12'd1;
   assign pc_plus2 = pc_ff + 12'd2;
   assign ret_idx  = (sp_ff == '0) ? SP_TOP : sp_ff - SP_W'(1);

   // long vector in the second word cycle, short vector otherwise
   always_comb begin
      if (state_ff == ST_WORD2) begin
         mv_term   = op;
         mv_dx_mag = word2[9:0];
         mv_dx_neg = word2[10];
         mv_dy_mag = word1[9:0];
         mv_dy_neg = word1[10];
      end else begin
         mv_term   = SHORT_TERM + {2'd0, word1[3], 1'b0} + {3'd0, word1[11]};
         mv_dx_mag = {word1[1:0], 8'd0};
         mv_dx_neg = word1[2];
         mv_dy_mag = {word1[9:8], 8'd0};
         mv_dy_neg = word1[10];
      end
   end

   assign mv_sum   = scale_ff + mv_term;
   assign mv_shift = (mv_sum > SCALE_TOP) ? SHIFT_FLOOR : SCALE_TOP - mv_sum;
   assign moved_x  = beam_x_ff + delta_step(mv_dx_mag, mv_dx_neg, mv_shift);
   assign moved_y  = beam_y_ff - delta_step(mv_dy_mag, mv_dy_neg, mv_shift);

   // absolute beam position relative to the visible area, in 1/1024 units
   assign diff_x = {word2[11], word2[11:0]} - {x_min_ff[11], x_min_ff};
   assign diff_y = {y_max_ff[11], y_max_ff} - {word1[11], word1[11:0]};
   assign abs_x  = {{9{diff_x[12]}}, diff_x, 10'd0};
   assign abs_y  = {{9{diff_y[12]}}, diff_y, 10'd0};

   // ------------------------------------------------------------ execution
   always_comb begin
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      scale_in  = scale_ff;
      beam_x_in = beam_x_ff;
      beam_y_in = beam_y_ff;
      run_in    = run_ff;
      busy_in   = busy_ff;
      push      = 1'b0;
      done_req  = 1'b0;
      go_word2  = 1'b0;
      res.draw      = 1'b0;
      res.intensity = 4'd0;
      res.error     = ERR_NONE;

      unique case (state_ff)
         ST_IDLE: ;
         ST_HOST: begin
            done_req = 1'b1;
            unique case (kind_ff)
               KIND_START: begin
                  // a start while busy is dropped
                  if (!busy_ff) begin
                     busy_in   = 1'b1;
                     run_in    = 1'b1;
                     pc_in     = '0;
                     sp_in     = '0;
                     scale_in  = '0;
                     beam_x_in = '0;
                     beam_y_in = '0;
                  end
               end
               KIND_CLEAR: busy_in = 1'b0;
               default: ;
            endcase
         end
         ST_WORD1: begin
            if (!run_ff) begin
               done_req = 1'b1;
            end else begin
               unique case (op) inside
                  [OP_LONG_FIRST:OP_ABS]: go_word2 = 1'b1;
                  OP_HALT: begin
                     done_req = 1'b1;
                     run_in   = 1'b0;
                     pc_in    = pc_plus1;
                  end
                  OP_CALL: begin
                     // a full stack still takes the call, then halts
                     done_req = 1'b1;
                     push     = 1'b1;
                     pc_in    = word1[11:0];
                     if (sp_ff == SP_TOP) begin
                        run_in    = 1'b0;
                        sp_in     = '0;
                        res.error = ERR_OVERFLOW;
                     end else begin
                        sp_in = sp_ff + SP_W'(1);
                     end
                  end
                  OP_RET: begin
                     // an empty stack halts and returns through the top entry
                     done_req = 1'b1;
                     sp_in    = ret_idx;
                     pc_in    = stack_ff[ret_idx];
                     if (sp_ff == '0) begin
                        run_in    = 1'b0;
                        res.error = ERR_UNDERFLOW;
                     end
                  end
                  OP_JUMP: begin
                     done_req = 1'b1;
                     pc_in    = word1[11:0];
                  end
                  OP_SHORT: begin
                     done_req      = 1'b1;
                     pc_in         = pc_plus1;
                     beam_x_in     = moved_x;
                     beam_y_in     = moved_y;
                     res.draw      = 1'b1;
                     res.intensity = word1[7:4];
                  end
                  default: ;
               endcase
            end
         end
         ST_WORD2: begin
            done_req = 1'b1;
            pc_in    = pc_plus2;
            if (op == OP_ABS) begin
               scale_in  = word2[15:12];
               beam_x_in = abs_x;
               beam_y_in = abs_y;
            end else begin
               beam_x_in     = moved_x;
               beam_y_in     = moved_y;
               res.draw      = 1'b1;
               res.intensity = word2[15:12];
            end
         end
         default: ;
      endcase

      res.running = run_in;
      res.busy    = busy_in;
   end

   // an item completes only when the staging register can take its result
   assign done   = done_req && m_load;
   assign free   = (state_ff == ST_IDLE) || done;
   assign accept = req_if.valid && free;
   assign req_if.ready = free;

   always_comb begin
      state_in = state_ff;
      if (free) begin
         if (accept) begin
            state_in = (req_kind == KIND_EXEC) ? ST_WORD1 : ST_HOST;
         end else begin
            state_in = ST_IDLE;
         end
      end else if (go_word2) begin
         state_in = ST_WORD2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         sp_ff     <= '0;
         scale_ff  <= '0;
         beam_x_ff <= '0;
         beam_y_ff <= '0;
         run_ff    <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done) begin
            pc_ff     <= pc_in;
            sp_ff     <= sp_in;
            scale_ff  <= scale_in;
            beam_x_ff <= beam_x_in;
            beam_y_ff <= beam_y_in;
            run_ff    <= run_in;
            busy_ff   <= busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
      end
      if (go_word2) begin
         w1_ff <= rd_data_ff;
      end
      if (done && push) begin
         stack_ff[sp_ff] <= pc_plus1;
      end
   end

   // ------------------------------------------------------------ vector memory
   // writes land at accept, reads issue at accept or for the second word;
   // a later step always reads after an earlier write, so no bypass is needed
   assign mem_we = accept && (req_kind == KIND_WRITE);
   assign mem_re = go_word2 || (accept && (req_kind == KIND_EXEC));

   always_comb begin
      if (mem_we) begin
         mem_addr = wrap_addr(req_if.word_addr);
      end else if (go_word2) begin
         mem_addr = wrap_addr(pc_plus1);
      end else begin
         mem_addr = wrap_addr(pc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[mem_addr] <= req_if.word_data;
      end else if (mem_re) begin
         rd_data_ff <= vmem[mem_addr];
      end
   end

   // ------------------------------------------------------------ result pipeline
   assign o_load = !o_valid_ff || rsp_if.ready;
   assign p_load = !p_valid_ff || o_load;
   assign m_load = !m_valid_ff || p_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_load) begin
            m_valid_ff <= done;
         end
         if (p_load) begin
            p_valid_ff <= m_valid_ff;
         end
         if (o_load) begin
            o_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_res_ff <= res;
         m_bx_ff  <= beam_x_in;
         m_by_ff  <= beam_y_in;
      end
      if (p_load) begin
         p_res_ff <= m_res_ff;
      end
      if (o_load) begin
         o_res_ff <= p_res_ff;
         o_x_ff   <= p_res_ff.draw ? x_sat : 16'd0;
         o_y_ff   <= p_res_ff.draw ? y_sat : 16'd0;
      end
   end

   dvg_screen u_screen_x (
      .clock  (clock),
      .load   (p_load),
      .beam   (m_bx_ff),
      .scale  (x_scale_ff),
      .screen (x_sat)
   );

   dvg_screen u_screen_y (
      .clock  (clock),
      .load   (p_load),
      .beam   (m_by_ff),
      .scale  (y_scale_ff),
      .screen (y_sat)
   );

   assign rsp_if.valid      = o_valid_ff;
   assign rsp_if.draw_valid = o_res_ff.draw;
   assign rsp_if.x_screen   = o_x_ff;
   assign rsp_if.y_screen   = o_y_ff;
   assign rsp_if.intensity  = o_res_ff.intensity;
   assign rsp_if.running    = o_res_ff.running;
   assign rsp_if.busy_res   = o_res_ff.busy;
   assign rsp_if.error_code = o_res_ff.error;

endmodule
`default_nettype wire
